// File: rtl/tcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types, codes and helpers of the transport connection sequencer.
// ----------------------------------------------------------------------------
package tcs_pkg;

    // command codes
    localparam logic CMD_RECEIVE = 1'b0;
    localparam logic CMD_SEND    = 1'b1;

    // transport control field kinds
    localparam logic [1:0] TPCI_UNNUM_CTRL = 2'd0;
    localparam logic [1:0] TPCI_NUM_CTRL   = 2'd1;
    localparam logic [1:0] TPCI_UNNUM_DATA = 2'd2;
    localparam logic [1:0] TPCI_NUM_DATA   = 2'd3;

    // control kinds (connect/ack share a code, disconnect/nack share a code)
    localparam logic [1:0] KIND_CONNECT    = 2'd0;
    localparam logic [1:0] KIND_DISCONNECT = 2'd1;
    localparam logic [1:0] KIND_ACK        = 2'd0;
    localparam logic [1:0] KIND_NACK       = 2'd1;

    // data actions
    localparam logic [1:0] ACT_DROP = 2'd0;
    localparam logic [1:0] ACT_UP   = 2'd1;
    localparam logic [1:0] ACT_DOWN = 2'd2;

    // control octets
    localparam logic [7:0] CTRL_DISCONNECT = 8'h81;
    localparam logic [7:0] CTRL_ACK        = 8'hc2;
    localparam logic [7:0] CTRL_SEQ_FLAG   = 8'h40;
    localparam logic [7:0] CTRL_SEQ_MASK   = 8'h3c;

    // one telegram header request
    typedef struct packed {
        logic        command;
        logic        well_formed;
        logic [1:0]  tpci_kind;
        logic [1:0]  control_kind;
        logic [3:0]  seq_no;
        logic [15:0] src_address;
        logic [15:0] dst_address;
        logic [1:0]  priority_req;
    } t_request;

    // one result
    typedef struct packed {
        logic [1:0]  data_action;
        logic [3:0]  data_seq;
        logic        control_send;
        logic [7:0]  control_byte;
        logic [15:0] control_dst;
        logic [15:0] control_src;
        logic [1:0]  control_priority;
        logic        connected_now;
        logic [15:0] peer_now;
        logic [3:0]  send_seq_now;
        logic [3:0]  recv_seq_now;
    } t_result;

    // insert a sequence number into bits 5..2 when the sequence flag is set
    function automatic logic [7:0] make_control(input logic [7:0] base,
                                                input logic [3:0] seq);
        logic [7:0] c;
        c = base;
        if ((c & CTRL_SEQ_FLAG) != 8'h00) begin
            c = (c & ~CTRL_SEQ_MASK) | {2'b00, seq, 2'b00};
        end
        return c;
    endfunction

endpackage

// File: rtl/transport_connection_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transport_connection_sequencer_top
// Single-connection transport layer sequencer: checks and stamps telegram
// headers, tracks the link and emits disconnect or ack control octets.
//
//   channel   handshake                   direction  payload
//   request   i_in_valid / o_in_stall     in         telegram header fields
//   result    o_out_valid / i_out_stall   out        action, control, state
//
// One request per cycle while o_in_stall is low; a request passes the input
// register into the result buffer and shows at the output from its head.
// The decision logic sits between the input register and a two-entry
// result buffer; o_in_stall comes from registers only.
// Synchronous active-low reset clears the link, peer and both counters.
// While the result side stalls, up to three requests are held before
// o_in_stall rises.
// ----------------------------------------------------------------------------
module transport_connection_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic        i_well_formed,
    input  logic [1:0]  i_tpci_kind,
    input  logic [1:0]  i_control_kind,
    input  logic [3:0]  i_seq_no,
    input  logic [15:0] i_src_address,
    input  logic [15:0] i_dst_address,
    input  logic [1:0]  i_priority_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_data_action,
    output logic [3:0]  o_data_seq,
    output logic        o_control_send,
    output logic [7:0]  o_control_byte,
    output logic [15:0] o_control_dst,
    output logic [15:0] o_control_src,
    output logic [1:0]  o_control_priority,
    output logic        o_connected_now,
    output logic [15:0] o_peer_now,
    output logic [3:0]  o_send_seq_now,
    output logic [3:0]  o_recv_seq_now
);
    import tcs_pkg::*;

    logic     r_in_valid;
    t_request r_in;
    logic     room;
    logic     fire;
    logic     in_take;
    t_result  res;
    t_result  out_res;

    assign fire       = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;
    assign in_take    = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take || fire) begin
            r_in_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.command      <= i_command;
            r_in.well_formed  <= i_well_formed;
            r_in.tpci_kind    <= i_tpci_kind;
            r_in.control_kind <= i_control_kind;
            r_in.seq_no       <= i_seq_no;
            r_in.src_address  <= i_src_address;
            r_in.dst_address  <= i_dst_address;
            r_in.priority_req <= i_priority_req;
        end
    end

    // decision and connection state
    tcs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (r_in),
        .o_res   (res)
    );

    // result buffer
    tcs_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (res),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_res)
    );

    // result fields
    assign o_data_action      = out_res.data_action;
    assign o_data_seq         = out_res.data_seq;
    assign o_control_send     = out_res.control_send;
    assign o_control_byte     = out_res.control_byte;
    assign o_control_dst      = out_res.control_dst;
    assign o_control_src      = out_res.control_src;
    assign o_control_priority = out_res.control_priority;
    assign o_connected_now    = out_res.connected_now;
    assign o_peer_now         = out_res.peer_now;
    assign o_send_seq_now     = out_res.send_seq_now;
    assign o_recv_seq_now     = out_res.recv_seq_now;

endmodule

// File: rtl/tcs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_core
// Connection state registers and the per-request decision logic.
// ----------------------------------------------------------------------------
module tcs_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  tcs_pkg::t_request i_req,
    output tcs_pkg::t_result  o_res
);
    import tcs_pkg::*;

    logic        r_link_up, n_link_up;
    logic [15:0] r_peer, n_peer;
    logic [3:0]  r_send_seq, n_send_seq;
    logic [3:0]  r_recv_seq, n_recv_seq;

    logic       from_peer;
    logic [1:0] action;
    logic [3:0] dseq;
    logic       ctrl;
    logic [7:0] cbyte;

    // decision for the request in the input register
    always_comb begin
        n_link_up  = r_link_up;
        n_peer     = r_peer;
        n_send_seq = r_send_seq;
        n_recv_seq = r_recv_seq;
        action     = ACT_DROP;
        dseq       = i_req.seq_no;
        ctrl       = 1'b0;
        cbyte      = 8'h00;
        from_peer  = r_link_up && (i_req.src_address == r_peer);

        if (i_req.command == CMD_RECEIVE) begin
            if (i_req.well_formed) begin
                case (i_req.tpci_kind)
                    TPCI_UNNUM_CTRL: begin
                        if (i_req.control_kind == KIND_CONNECT) begin
                            if (!r_link_up) begin
                                n_link_up  = 1'b1;
                                n_send_seq = 4'd0;
                                n_recv_seq = 4'd0;
                                n_peer     = i_req.src_address;
                            end
                        end else if (i_req.control_kind == KIND_DISCONNECT) begin
                            if (from_peer) begin
                                n_link_up = 1'b0;
                            end
                        end
                    end
                    TPCI_NUM_CTRL: begin
                        if (i_req.control_kind == KIND_ACK) begin
                            if (from_peer && (i_req.seq_no == r_send_seq)) begin
                                n_send_seq = r_send_seq + 4'd1;
                            end
                        end else if (i_req.control_kind == KIND_NACK) begin
                            if (from_peer) begin
                                n_link_up = 1'b0;
                                ctrl      = 1'b1;
                                cbyte     = make_control(CTRL_DISCONNECT, 4'd0);
                            end
                        end
                    end
                    TPCI_UNNUM_DATA: begin
                        action = ACT_UP;
                    end
                    default: begin
                        // numbered data from the peer
                        if (from_peer) begin
                            ctrl = 1'b1;
                            if (i_req.seq_no != r_recv_seq) begin
                                cbyte     = make_control(CTRL_DISCONNECT, 4'd0);
                                n_link_up = 1'b0;
                            end else begin
                                action     = ACT_UP;
                                n_recv_seq = i_req.seq_no + 4'd1;
                                cbyte      = make_control(CTRL_ACK, i_req.seq_no);
                            end
                        end
                    end
                endcase
            end
        end else begin
            // outgoing numbered data needs the link and gets stamped
            if (i_req.tpci_kind == TPCI_NUM_DATA) begin
                if (r_link_up && (i_req.dst_address == r_peer)) begin
                    action = ACT_DOWN;
                    dseq   = r_send_seq;
                end
            end else begin
                action = ACT_DOWN;
            end
        end

        o_res.data_action      = action;
        o_res.data_seq         = dseq;
        o_res.control_send     = ctrl;
        o_res.control_byte     = ctrl ? cbyte : 8'h00;
        o_res.control_dst      = ctrl ? i_req.src_address : 16'h0000;
        o_res.control_src      = ctrl ? i_req.dst_address : 16'h0000;
        o_res.control_priority = ctrl ? i_req.priority_req : 2'd0;
        o_res.connected_now    = n_link_up;
        o_res.peer_now         = n_peer;
        o_res.send_seq_now     = n_send_seq;
        o_res.recv_seq_now     = n_recv_seq;
    end

    // connection state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_up  <= 1'b0;
            r_peer     <= 16'h0000;
            r_send_seq <= 4'd0;
            r_recv_seq <= 4'd0;
        end else if (i_fire) begin
            r_link_up  <= n_link_up;
            r_peer     <= n_peer;
            r_send_seq <= n_send_seq;
            r_recv_seq <= n_recv_seq;
        end
    end

endmodule

// File: rtl/tcs_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_outq
// Two-entry result buffer; its fill level gates new work without a path
// from the downstream stall.
// ----------------------------------------------------------------------------
module tcs_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tcs_pkg::t_result i_data,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_stall,
    output tcs_pkg::t_result o_data
);
    import tcs_pkg::*;

    t_result    r_q [2];
    t_result    n_q0, n_q1;
    logic [1:0] r_count, n_count;
    logic       pop;
    logic       wr_slot;

    assign pop     = (r_count != 2'd0) && !i_stall;
    assign o_valid = (r_count != 2'd0);
    assign o_room  = (r_count != 2'd2);
    assign o_data  = r_q[0];

    // slot for the new result once the head has left
    always_comb begin
        n_count = r_count + {1'b0, i_push} - {1'b0, pop};
        wr_slot = ((r_count - {1'b0, pop}) != 2'd0);
    end

    // next contents: shift on pop, then place the new result
    always_comb begin
        n_q0 = r_q[0];
        n_q1 = r_q[1];
        if (pop) begin
            n_q0 = r_q[1];
        end
        if (i_push) begin
            if (wr_slot) begin
                n_q1 = i_data;
            end else begin
                n_q0 = i_data;
            end
        end
    end

    // fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q0;
        r_q[1] <= n_q1;
    end

endmodule
